// File: rtl/core/vsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsi_pkg
// Shared step codes, command/status structs and helpers for the steering
// integrator.
// ----------------------------------------------------------------------------
package vsi_pkg;

    // sequencer step codes
    localparam logic [5:0] S_LIM  = 6'd0;
    localparam logic [5:0] S_VV0  = 6'd1;
    localparam logic [5:0] S_VV1  = 6'd2;
    localparam logic [5:0] S_SPD  = 6'd3;
    localparam logic [5:0] S_FF0  = 6'd4;
    localparam logic [5:0] S_FF1  = 6'd5;
    localparam logic [5:0] S_FL   = 6'd6;
    localparam logic [5:0] S_R    = 6'd7;
    localparam logic [5:0] S_R2   = 6'd8;
    localparam logic [5:0] S_R4   = 6'd9;
    localparam logic [5:0] S_R8   = 6'd10;
    localparam logic [5:0] S_R16  = 6'd11;
    localparam logic [5:0] S_R20  = 6'd12;
    localparam logic [5:0] S_FWX  = 6'd13;
    localparam logic [5:0] S_FWY  = 6'd14;
    localparam logic [5:0] S_DX   = 6'd15;
    localparam logic [5:0] S_DY   = 6'd16;
    localparam logic [5:0] S_DOT0 = 6'd17;
    localparam logic [5:0] S_DOT1 = 6'd18;
    localparam logic [5:0] S_PJ0  = 6'd19;
    localparam logic [5:0] S_PJ1  = 6'd20;
    localparam logic [5:0] S_PX   = 6'd21;
    localparam logic [5:0] S_PY   = 6'd22;
    localparam logic [5:0] S_PP0  = 6'd23;
    localparam logic [5:0] S_PP1  = 6'd24;
    localparam logic [5:0] S_PL   = 6'd25;
    localparam logic [5:0] S_PUN  = 6'd26;
    localparam logic [5:0] S_PUX  = 6'd27;
    localparam logic [5:0] S_PUY  = 6'd28;
    localparam logic [5:0] S_SN0  = 6'd29;
    localparam logic [5:0] S_SN   = 6'd30;
    localparam logic [5:0] S_UX0  = 6'd31;
    localparam logic [5:0] S_UX1  = 6'd32;
    localparam logic [5:0] S_UY0  = 6'd33;
    localparam logic [5:0] S_UY1  = 6'd34;
    localparam logic [5:0] S_BX   = 6'd35;
    localparam logic [5:0] S_BY   = 6'd36;
    localparam logic [5:0] S_CL0  = 6'd37;
    localparam logic [5:0] S_CL1  = 6'd38;
    localparam logic [5:0] S_CLQ  = 6'd39;
    localparam logic [5:0] S_CX0  = 6'd40;
    localparam logic [5:0] S_CXD  = 6'd41;
    localparam logic [5:0] S_CY0  = 6'd42;
    localparam logic [5:0] S_CYD  = 6'd43;
    localparam logic [5:0] S_AX   = 6'd44;
    localparam logic [5:0] S_AY   = 6'd45;
    localparam logic [5:0] S_VX   = 6'd46;
    localparam logic [5:0] S_VY   = 6'd47;
    localparam logic [5:0] S_NS0  = 6'd48;
    localparam logic [5:0] S_NS1  = 6'd49;
    localparam logic [5:0] S_NSQ  = 6'd50;
    localparam logic [5:0] S_SX0  = 6'd51;
    localparam logic [5:0] S_SXD  = 6'd52;
    localparam logic [5:0] S_SY0  = 6'd53;
    localparam logic [5:0] S_SYD  = 6'd54;
    localparam logic [5:0] S_DONE = 6'd55;

    localparam logic [23:0] MAX_SPEED_RST = 24'd131072;
    localparam logic [2:0]  REG_MAX_SPEED = 3'd0;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic [5:0] step;
        logic       start;
        logic       capture;
        logic       load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic busy;
        logic dt_zero;
        logic cone_ok;
        logic bend;
        logic plen_small;
        logic clip;
        logic cap;
        logic out_free;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
        if (x > 70'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -70'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic is_div(input logic [5:0] s);
        return (s inside {S_R, S_FWX, S_FWY, S_DX, S_DY, S_PUX, S_PUY,
                          S_CXD, S_CYD, S_SXD, S_SYD});
    endfunction

    function automatic logic is_sqrt(input logic [5:0] s);
        return (s inside {S_SPD, S_FL, S_PL, S_SN, S_CLQ, S_NSQ});
    endfunction

endpackage

// File: rtl/core/vsi_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsi_sqrt
// 64-bit floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vsi_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_op,
    output logic        o_busy,
    output logic [31:0] o_root,
    output logic        o_rem_nz
);
    logic [63:0] r_n, r_res, r_bit;
    logic        r_busy;
    logic [63:0] sum;

    assign sum = r_res + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_busy <= (r_bit != 64'd1);
        end
    end

    // digit recurrence
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_op;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_n >= sum) begin
                r_n   <= r_n - sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy   = r_busy;
    assign o_root   = r_res[31:0];
    assign o_rem_nz = (r_n != 64'd0);
endmodule

// File: rtl/core/vsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsi_div
// Signed 64-bit by positive 34-bit restoring divider, truncating toward zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic        [33:0] i_den,
    output logic               o_busy,
    output logic signed [63:0] o_quo
);
    logic [63:0] r_mag, r_quo;
    logic [33:0] r_rem, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [34:0] trial;
    logic        fits;

    assign trial = {r_rem, r_mag[63]};
    assign fits  = (trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 6'd1;
            r_busy <= (r_cnt != 6'd63);
        end
    end

    // shift-subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[63];
            r_mag <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? 34'(trial - {1'b0, r_den}) : trial[33:0];
            r_quo <= {r_quo[62:0], fits};
            r_mag <= {r_mag[62:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

// File: rtl/core/vsi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsi_datapath
// Working registers, shared multiplier, square root and divider, and the
// output register of the steering integrator.
// ----------------------------------------------------------------------------
module vsi_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vsi_pkg::t_cmd         i_cmd,
    output vsi_pkg::t_status      o_st,
    input  logic           [23:0] i_max_speed,
    input  logic signed    [31:0] i_force_x,
    input  logic signed    [31:0] i_force_y,
    input  logic           [15:0] i_delta_time,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic signed    [31:0] o_velocity_x,
    output logic signed    [31:0] o_velocity_y,
    output logic signed    [31:0] o_accel_x,
    output logic signed    [31:0] o_accel_y,
    output logic                  o_skipped
);
    import vsi_pkg::*;

    localparam int EPS = ((1 << FRAC_BITS) + 5000) / 10000;

    // item and state registers
    logic signed [31:0] r_fx, r_fy, r_vx, r_vy, r_ax, r_ay;
    logic        [15:0] r_dt;
    logic        [14:0] r_rate;
    // intermediates
    logic        [21:0] r_limit;
    logic        [31:0] r_speed, r_fl, r_plen, r_clen, r_ns;
    logic        [32:0] r_vceil, r_fceil, r_pceil;
    logic        [30:0] r_r, r_r2, r_r4, r_r8, r_r16, r_sine;
    logic signed [31:0] r_cone, r_fwx, r_fwy, r_dx, r_dy, r_pux, r_puy;
    logic signed [32:0] r_ux, r_uy;
    logic signed [33:0] r_proj;
    logic signed [34:0] r_px, r_py;
    logic               r_bend;
    logic signed [69:0] r_acc, r_prod, acc_sum;
    logic signed [34:0] r_ma, r_mb, mul_a, mul_b;
    logic               r_mpend, r_ovalid;

    logic signed [63:0] div_n, div_q;
    logic        [33:0] div_d;
    logic               div_busy, sq_busy, sq_nz;
    logic        [31:0] sq_root;
    logic        [19:0] rate_raw;
    logic        [32:0] root_ceil;
    logic               out_free;

    assign acc_sum   = r_acc + r_prod;
    assign root_ceil = {1'b0, sq_root} + {32'd0, sq_nz};
    assign rate_raw  = 20'(i_delta_time) * 20'd9;
    assign out_free  = !r_ovalid || !i_stall;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.step)
            S_LIM:  begin mul_a = 35'(i_max_speed); mul_b = 35'sd13421773; end
            S_VV0:  begin mul_a = 35'(r_vx); mul_b = 35'(r_vx); end
            S_VV1:  begin mul_a = 35'(r_vy); mul_b = 35'(r_vy); end
            S_FF0:  begin mul_a = 35'(r_fx); mul_b = 35'(r_fx); end
            S_FF1:  begin mul_a = 35'(r_fy); mul_b = 35'(r_fy); end
            S_R2:   begin mul_a = 35'(r_r);  mul_b = 35'(r_r); end
            S_R4:   begin mul_a = 35'(r_r2); mul_b = 35'(r_r2); end
            S_R8:   begin mul_a = 35'(r_r4); mul_b = 35'(r_r4); end
            S_R16:  begin mul_a = 35'(r_r8); mul_b = 35'(r_r8); end
            S_R20:  begin mul_a = 35'(r_r16); mul_b = 35'(r_r4); end
            S_DOT0: begin mul_a = 35'(r_dx); mul_b = 35'(r_fwx); end
            S_DOT1: begin mul_a = 35'(r_dy); mul_b = 35'(r_fwy); end
            S_PJ0:  begin mul_a = 35'(r_fx); mul_b = 35'(r_fwx); end
            S_PJ1:  begin mul_a = 35'(r_fy); mul_b = 35'(r_fwy); end
            S_PX:   begin mul_a = 35'(r_proj); mul_b = 35'(r_fwx); end
            S_PY:   begin mul_a = 35'(r_proj); mul_b = 35'(r_fwy); end
            S_PP0:  begin mul_a = r_px; mul_b = r_px; end
            S_PP1:  begin mul_a = r_py; mul_b = r_py; end
            S_SN0:  begin mul_a = 35'(r_cone); mul_b = 35'(r_cone); end
            S_UX0:  begin mul_a = 35'(r_fwx); mul_b = 35'(r_cone); end
            S_UX1:  begin mul_a = 35'(r_pux); mul_b = 35'(r_sine); end
            S_UY0:  begin mul_a = 35'(r_fwy); mul_b = 35'(r_cone); end
            S_UY1:  begin mul_a = 35'(r_puy); mul_b = 35'(r_sine); end
            S_BX:   begin mul_a = 35'(r_ux); mul_b = 35'(r_fl); end
            S_BY:   begin mul_a = 35'(r_uy); mul_b = 35'(r_fl); end
            S_CL0:  begin mul_a = 35'(r_fx); mul_b = 35'(r_fx); end
            S_CL1:  begin mul_a = 35'(r_fy); mul_b = 35'(r_fy); end
            S_CX0:  begin mul_a = 35'(r_fx); mul_b = 35'({i_max_speed, 2'b00}); end
            S_CY0:  begin mul_a = 35'(r_fy); mul_b = 35'({i_max_speed, 2'b00}); end
            S_AX:   begin mul_a = 35'(r_fx) - 35'(r_ax); mul_b = 35'(r_rate); end
            S_AY:   begin mul_a = 35'(r_fy) - 35'(r_ay); mul_b = 35'(r_rate); end
            S_VX:   begin mul_a = 35'(r_ax); mul_b = 35'(r_dt); end
            S_VY:   begin mul_a = 35'(r_ay); mul_b = 35'(r_dt); end
            S_NS0:  begin mul_a = 35'(r_vx); mul_b = 35'(r_vx); end
            S_NS1:  begin mul_a = 35'(r_vy); mul_b = 35'(r_vy); end
            S_SX0:  begin mul_a = 35'(r_vx); mul_b = 35'(i_max_speed); end
            S_SY0:  begin mul_a = 35'(r_vy); mul_b = 35'(i_max_speed); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // divider operand select
    always_comb begin
        div_n = '0;
        div_d = 34'd1;
        case (i_cmd.step)
            S_R:   begin div_n = {2'b00, r_speed, 30'd0}; div_d = 34'(r_limit); end
            S_FWX: begin div_n = 64'(r_vx) <<< 30; div_d = 34'(r_vceil); end
            S_FWY: begin div_n = 64'(r_vy) <<< 30; div_d = 34'(r_vceil); end
            S_DX:  begin div_n = 64'(r_fx) <<< 30; div_d = 34'(r_fceil); end
            S_DY:  begin div_n = 64'(r_fy) <<< 30; div_d = 34'(r_fceil); end
            S_PUX: begin div_n = 64'(r_px) <<< 30; div_d = 34'(r_pceil); end
            S_PUY: begin div_n = 64'(r_py) <<< 30; div_d = 34'(r_pceil); end
            S_CXD, S_CYD: begin div_n = r_acc[63:0]; div_d = 34'(r_clen); end
            S_SXD, S_SYD: begin div_n = r_acc[63:0]; div_d = 34'(r_ns); end
            default: begin div_n = '0; div_d = 34'd1; end
        endcase
    end

    vsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && is_div(i_cmd.step)),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_busy  (div_busy),
        .o_quo   (div_q)
    );

    vsi_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start && is_sqrt(i_cmd.step)),
        .i_op     (r_acc[63:0]),
        .o_busy   (sq_busy),
        .o_root   (sq_root),
        .o_rem_nz (sq_nz)
    );

    // multiplier: registered operands, registered product
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ma <= mul_a;
            r_mb <= mul_b;
        end
        r_prod <= r_ma * r_mb;
    end

    // control registers and vehicle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpend  <= 1'b0;
            r_ovalid <= 1'b0;
            r_vx     <= '0;
            r_vy     <= '0;
            r_ax     <= '0;
            r_ay     <= '0;
        end else begin
            r_mpend <= i_cmd.start;
            if (i_cmd.load_out)
                r_ovalid <= 1'b1;
            else if (!i_stall)
                r_ovalid <= 1'b0;
            if (i_cmd.capture) begin
                case (i_cmd.step)
                    S_AX:  r_ax <= sat32(70'(r_ax) + (r_prod >>> 16));
                    S_AY:  r_ay <= sat32(70'(r_ay) + (r_prod >>> 16));
                    S_VX:  r_vx <= sat32(70'(r_vx) + (r_prod >>> 16));
                    S_VY:  r_vy <= sat32(70'(r_vy) + (r_prod >>> 16));
                    S_SXD: r_vx <= div_q[31:0];
                    S_SYD: r_vy <= div_q[31:0];
                    default: ;
                endcase
            end
        end
    end

    // item latch and step results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_fx   <= i_force_x;
            r_fy   <= i_force_y;
            r_dt   <= i_delta_time;
            r_rate <= (rate_raw < 20'd9830)  ? 15'd9830 :
                      (rate_raw > 20'd26214) ? 15'd26214 : rate_raw[14:0];
        end
        if (i_cmd.capture) begin
            case (i_cmd.step)
                S_LIM:  r_limit <= r_prod[47:26];
                S_VV0, S_FF0, S_PP0, S_CL0, S_NS0,
                S_CX0, S_CY0, S_SX0, S_SY0, S_DOT0,
                S_PJ0, S_UX0, S_UY0: r_acc <= r_prod;
                S_VV1, S_FF1, S_PP1, S_CL1, S_NS1: r_acc <= acc_sum;
                S_SPD:  begin r_speed <= sq_root; r_vceil <= root_ceil; end
                S_FL:   begin r_fl <= sq_root; r_fceil <= root_ceil; end
                S_PL:   begin r_plen <= sq_root; r_pceil <= root_ceil; end
                S_CLQ:  r_clen <= sq_root;
                S_NSQ:  r_ns <= sq_root;
                S_SN:   r_sine <= sq_root[30:0];
                S_R:    r_r <= div_q[30:0];
                S_R2:   r_r2 <= 31'(r_prod >>> 30);
                S_R4:   r_r4 <= 31'(r_prod >>> 30);
                S_R8:   r_r8 <= 31'(r_prod >>> 30);
                S_R16:  r_r16 <= 31'(r_prod >>> 30);
                S_R20:  r_cone <= 32'(70'sd1073741824 - ((r_prod >>> 30) <<< 1));
                S_FWX:  r_fwx <= div_q[31:0];
                S_FWY:  r_fwy <= div_q[31:0];
                S_DX:   r_dx <= div_q[31:0];
                S_DY:   r_dy <= div_q[31:0];
                S_DOT1: r_bend <= ((acc_sum >>> 30) < 70'(r_cone));
                S_PJ1:  r_proj <= 34'(acc_sum >>> 30);
                S_PX:   r_px <= 35'(r_fx) - 35'(r_prod >>> 30);
                S_PY:   r_py <= 35'(r_fy) - 35'(r_prod >>> 30);
                S_PUN:  begin r_pux <= -r_fwy; r_puy <= r_fwx; end
                S_PUX:  r_pux <= div_q[31:0];
                S_PUY:  r_puy <= div_q[31:0];
                S_SN0:  r_acc <= 70'sh1000000000000000 - r_prod;
                S_UX1:  r_ux <= 33'(acc_sum >>> 30);
                S_UY1:  r_uy <= 33'(acc_sum >>> 30);
                S_BX:   r_fx <= sat32(r_prod >>> 30);
                S_BY:   r_fy <= sat32(r_prod >>> 30);
                S_CXD:  r_fx <= div_q[31:0];
                S_CYD:  r_fy <= div_q[31:0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_velocity_x <= r_vx;
            o_velocity_y <= r_vy;
            o_accel_x    <= r_ax;
            o_accel_y    <= r_ay;
            o_skipped    <= (r_dt == 16'd0);
        end
    end

    assign o_valid = r_ovalid;

    // status
    always_comb begin
        o_st.busy       = r_mpend || div_busy || sq_busy;
        o_st.dt_zero    = (r_dt == 16'd0);
        o_st.cone_ok    = (r_speed <= 32'(r_limit)) && (r_fl != 32'd0) &&
                          (r_speed > 32'(EPS));
        o_st.bend       = r_bend;
        o_st.plen_small = (r_plen <= 32'(EPS));
        o_st.clip       = (r_clen > 32'({i_max_speed, 2'b00}));
        o_st.cap        = (r_ns > 32'(i_max_speed));
        o_st.out_free   = out_free;
    end
endmodule

// File: rtl/core/vsi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsi_ctrl
// Sequencer: walks the step list, starts units, waits, captures, branches.
// ----------------------------------------------------------------------------
module vsi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  vsi_pkg::t_status i_st,
    output vsi_pkg::t_cmd    o_cmd
);
    import vsi_pkg::*;

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_CHK   = 3'd1;
    localparam logic [2:0] P_ISSUE = 3'd2;
    localparam logic [2:0] P_WAIT  = 3'd3;
    localparam logic [2:0] P_CAPT  = 3'd4;
    localparam logic [2:0] P_NEXT  = 3'd5;
    localparam logic [2:0] P_OUT   = 3'd6;

    logic [2:0] r_phase, n_phase;
    logic [5:0] r_step, n_step;
    logic [5:0] nxt;

    // branch decisions, taken after the step's capture
    always_comb begin
        nxt = 6'(r_step + 6'd1);
        case (r_step)
            S_FL:   nxt = i_st.cone_ok ? S_R : S_CL0;
            S_DOT1: nxt = i_st.bend ? S_PJ0 : S_CL0;
            S_PL:   nxt = i_st.plen_small ? S_PUN : S_PUX;
            S_PUN:  nxt = S_SN0;
            S_CLQ:  nxt = i_st.clip ? S_CX0 : S_AX;
            S_NSQ:  nxt = i_st.cap ? S_SX0 : S_DONE;
            default: nxt = 6'(r_step + 6'd1);
        endcase
    end

    // phase machine
    always_comb begin
        n_phase        = r_phase;
        n_step         = r_step;
        o_cmd.accept   = 1'b0;
        o_cmd.step     = r_step;
        o_cmd.start    = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_phase)
            P_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_phase      = P_CHK;
                end
            end
            P_CHK: begin
                if (i_st.dt_zero) begin
                    n_phase = P_OUT;
                end else begin
                    n_step  = S_LIM;
                    n_phase = P_ISSUE;
                end
            end
            P_ISSUE: begin
                o_cmd.start = 1'b1;
                n_phase     = P_WAIT;
            end
            P_WAIT: begin
                if (!i_st.busy)
                    n_phase = P_CAPT;
            end
            P_CAPT: begin
                o_cmd.capture = 1'b1;
                n_phase       = P_NEXT;
            end
            P_NEXT: begin
                n_step  = nxt;
                n_phase = (nxt == S_DONE) ? P_OUT : P_ISSUE;
            end
            P_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_phase        = P_IDLE;
                end
            end
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_step  <= S_LIM;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

    assign o_stall = (r_phase != P_IDLE);
endmodule

// File: rtl/core/vehicle_steering_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_steering_integrator_unit
// Steering-force integrator: cone bending, force clip, smoothed acceleration,
// velocity integration and speed cap, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid / o_stall) takes one item: force x/y and a Q0.16
//  time step. Output channel (o_valid / i_stall) returns one item per input:
//  new velocity, smoothed acceleration and a skipped flag.
//  Items are processed one at a time by a sequencer over a shared multiplier,
//  a square root and a divider. Each item passes a check step; a zero time
//  step goes straight to the output step, else the multiply, square root and
//  division steps follow, with the cone bend, force clip and speed cap steps
//  run only when their checks ask for them, and an output step ends the item.
//  The output register frees the sequencer: a new item is accepted while a
//  finished one waits; if the receiver stalls, the next finished item waits
//  in the sequencer until the output register empties. Reset clears velocity
//  and acceleration to zero and max_speed to 2.0. max_speed sits at APB address
//  0; the user must write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module vehicle_steering_integrator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic        [15:0] i_delta_time,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_velocity_x,
    output logic signed [31:0] o_velocity_y,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic               o_skipped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    import vsi_pkg::*;

    logic [23:0] r_max_speed;
    t_cmd        cmd;
    t_status     st;
    logic        reg_hit;

    assign reg_hit = ({paddr[2], 2'b00} == REG_MAX_SPEED);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_max_speed <= pwdata[23:0];
        end
    end

    assign prdata = reg_hit ? {8'd0, r_max_speed} : 32'd0;
    assign pready = 1'b1;

    vsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    vsi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_max_speed  (r_max_speed),
        .i_force_x    (i_force_x),
        .i_force_y    (i_force_y),
        .i_delta_time (i_delta_time),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_velocity_x (o_velocity_x),
        .o_velocity_y (o_velocity_y),
        .o_accel_x    (o_accel_x),
        .o_accel_y    (o_accel_y),
        .o_skipped    (o_skipped)
    );
endmodule

// File: rtl/core/vsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsi_checker
// Port-level checks for the steering integrator, bound to the top level.
// ----------------------------------------------------------------------------
module vsi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_velocity_x,
    input logic signed [31:0] o_velocity_y,
    input logic signed [31:0] o_accel_x,
    input logic signed [31:0] o_accel_y,
    input logic               o_skipped,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic        [2:0]  paddr,
    input logic        [31:0] pwdata,
    input logic        [31:0] prdata
);
    // no result item right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // one item in flight: input stalls right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_velocity_x) &&
        $stable(o_velocity_y) && $stable(o_accel_x) && $stable(o_accel_y) &&
        $stable(o_skipped)))
        else $error("stalled result changed");

    // written max_speed reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2] |->
        (prdata == {8'd0, $past(pwdata[23:0])}))
        else $error("max_speed readback mismatch");
endmodule

bind vehicle_steering_integrator_unit vsi_checker u_vsi_checker (.*);

// File: tb/sv/vehicle_steering_integrator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_steering_integrator_unit_tb
// Self-checking bench for the steering integrator. A bit-exact predictor
// follows the velocity and smoothed acceleration for each accepted item;
// results are checked in order, field by field. Covers directed corners,
// cone bending at low speed, force clip, speed cap, zero time steps, several
// max_speed settings, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module vehicle_steering_integrator_unit_tb;
    import vsi_pkg::*;

    localparam logic [2:0] ADDR_MAX_SPEED = 3'(REG_MAX_SPEED * 4);
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;
    localparam longint     EPS_Q          = 7;
    localparam longint     Q30_ONE        = 64'sd1073741824;
    localparam longint     BLEND_MIN      = 9830;
    localparam longint     BLEND_MAX      = 26214;

    typedef struct {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic               skipped;
    } t_motion;

    // Predictor of the vehicle state plus the queue of pending results
    class t_motion_scoreboard;
        longint   vel_x, vel_y, acc_x, acc_y, speed_max;
        t_motion  pending_q[$];
        int       errors, checked, bends, skips;

        function new();
            speed_max = MAX_SPEED_RST;
        endfunction

        static function longint unsigned root_floor(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        static function longint unsigned mag_sq(longint x, longint y);
            longint unsigned ax, ay;
            ax = x < 0 ? 64'd0 - longint'(x) : x;
            ay = y < 0 ? 64'd0 - longint'(y) : y;
            return ax * ax + ay * ay;
        endfunction

        static function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // floor length; Q30 direction divided by the ceiling length
        static function longint direction(longint x, longint y,
                                          output longint ux, output longint uy);
            longint unsigned n, r, c;
            n = mag_sq(x, y);
            r = root_floor(n);
            c = r + ((r * r < n) ? 1 : 0);
            if (c == 0) begin
                ux = 0;
                uy = 0;
            end else begin
                ux = (x * Q30_ONE) / longint'(c);
                uy = (y * Q30_ONE) / longint'(c);
            end
            return longint'(r);
        endfunction

        function void set_max_speed(logic [23:0] v);
            speed_max = v;
        endfunction

        // accepted input: advance the state and queue the expected result
        function void note_input(logic signed [31:0] f_x, logic signed [31:0] f_y,
                                 logic [15:0] dt_in);
            longint fx, fy, dt, speed, lim, flen, fwx, fwy, dx, dy, pux, puy;
            longint cone, proj, px, py, plen, sine, ux, uy, maxf, clen, blend, ns;
            longint unsigned r, r2, r4, r8, r16, r20;
            t_motion m;
            fx = f_x;
            fy = f_y;
            dt = dt_in;
            m.skipped = (dt == 0);
            if (dt != 0) begin
                speed = root_floor(mag_sq(vel_x, vel_y));
                lim = speed_max / 5;
                flen = root_floor(mag_sq(fx, fy));
                // bend a force outside the allowed cone while slow
                if (speed <= lim && flen > 0 && speed > EPS_Q) begin
                    r = (longint'(speed) << 30) / longint'(lim);
                    r2 = (r * r) >> 30;
                    r4 = (r2 * r2) >> 30;
                    r8 = (r4 * r4) >> 30;
                    r16 = (r8 * r8) >> 30;
                    r20 = (r16 * r4) >> 30;
                    cone = Q30_ONE - 2 * longint'(r20);
                    void'(direction(vel_x, vel_y, fwx, fwy));
                    void'(direction(fx, fy, dx, dy));
                    if (((dx * fwx + dy * fwy) >>> 30) < cone) begin
                        bends++;
                        proj = (fx * fwx + fy * fwy) >>> 30;
                        px = fx - ((proj * fwx) >>> 30);
                        py = fy - ((proj * fwy) >>> 30);
                        plen = direction(px, py, pux, puy);
                        if (plen <= EPS_Q) begin
                            pux = -fwy;
                            puy = fwx;
                        end
                        sine = root_floor(Q30_ONE * Q30_ONE - cone * cone);
                        ux = (fwx * cone + pux * sine) >>> 30;
                        uy = (fwy * cone + puy * sine) >>> 30;
                        fx = clamp32((ux * flen) >>> 30);
                        fy = clamp32((uy * flen) >>> 30);
                    end
                end
                // force clip
                maxf = speed_max * 4;
                clen = root_floor(mag_sq(fx, fy));
                if (clen > maxf) begin
                    fx = (fx * maxf) / clen;
                    fy = (fy * maxf) / clen;
                end
                // smoothing and integration
                blend = 9 * dt;
                if (blend < BLEND_MIN) blend = BLEND_MIN;
                if (blend > BLEND_MAX) blend = BLEND_MAX;
                acc_x = clamp32(acc_x + (((fx - acc_x) * blend) >>> 16));
                acc_y = clamp32(acc_y + (((fy - acc_y) * blend) >>> 16));
                vel_x = clamp32(vel_x + ((acc_x * dt) >>> 16));
                vel_y = clamp32(vel_y + ((acc_y * dt) >>> 16));
                // speed cap
                ns = root_floor(mag_sq(vel_x, vel_y));
                if (ns > speed_max) begin
                    vel_x = (vel_x * speed_max) / ns;
                    vel_y = (vel_y * speed_max) / ns;
                end
            end else begin
                skips++;
            end
            m.vel_x = vel_x[31:0];
            m.vel_y = vel_y[31:0];
            m.acc_x = acc_x[31:0];
            m.acc_y = acc_y[31:0];
            pending_q.push_back(m);
        endfunction

        function void check_result(t_motion got);
            t_motion e;
            if (pending_q.size() == 0) begin
                $error("result item with no expectation pending");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (got.vel_x !== e.vel_x) begin
                $error("velocity_x exp %0d act %0d", e.vel_x, got.vel_x);
                errors++;
            end
            if (got.vel_y !== e.vel_y) begin
                $error("velocity_y exp %0d act %0d", e.vel_y, got.vel_y);
                errors++;
            end
            if (got.acc_x !== e.acc_x) begin
                $error("accel_x exp %0d act %0d", e.acc_x, got.acc_x);
                errors++;
            end
            if (got.acc_y !== e.acc_y) begin
                $error("accel_y exp %0d act %0d", e.acc_y, got.acc_y);
                errors++;
            end
            if (got.skipped !== e.skipped) begin
                $error("skipped exp %0b act %0b", e.skipped, got.skipped);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_force_x;
    logic signed [31:0] i_force_y;
    logic        [15:0] i_delta_time;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_velocity_x;
    logic signed [31:0] o_velocity_y;
    logic signed [31:0] o_accel_x;
    logic signed [31:0] o_accel_y;
    logic               o_skipped;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic        [2:0]  paddr;
    logic        [31:0] pwdata;
    logic        [31:0] prdata;
    logic               pready;

    t_motion_scoreboard sb;
    bit                 idle_en;
    bit                 long_hold;
    int                 sent;

    vehicle_steering_integrator_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // output side: random stall bursts plus one long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall = 1'b1;
                repeat (3000) @(negedge i_clk);
                long_hold = 1'b0;
                i_stall = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // result monitor
    initial begin
        t_motion got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.vel_x = o_velocity_x;
                got.vel_y = o_velocity_y;
                got.acc_x = o_accel_x;
                got.acc_y = o_accel_y;
                got.skipped = o_skipped;
                sb.check_result(got);
            end
        end
    end

    // one item through the input handshake; called at a falling edge
    task automatic send_item(logic signed [31:0] fx, logic signed [31:0] fy,
                             logic [15:0] dt);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_force_x = fx;
        i_force_y = fy;
        i_delta_time = dt;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(fx, fy, dt);
        sent++;
        @(negedge i_clk);
    endtask

    // register write while idle; called at a falling edge
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        i_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == ADDR_MAX_SPEED) sb.set_max_speed(data[23:0]);
    endtask

    // random item: mostly modest forces and time steps that keep the
    // vehicle slow enough for cone bending, with wide values mixed in
    task automatic send_random();
        logic signed [31:0] fx, fy;
        logic [15:0] dt;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            fx = $signed($urandom_range(0, 2 * 65536)) - 65536;
            fy = $signed($urandom_range(0, 2 * 65536)) - 65536;
        end else if (kind < 55) begin
            // push against the direction of travel
            fx = 32'(-sb.vel_x * $urandom_range(1, 8));
            fy = 32'(-sb.vel_y * $urandom_range(1, 8) + $signed($urandom_range(0, 64)) - 32);
        end else if (kind < 75) begin
            fx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            fy = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        end else if (kind < 92) begin
            fx = $urandom();
            fy = $urandom();
        end else begin
            fx = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            fy = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        end
        kind = $urandom_range(0, 99);
        if (kind < 8) dt = 16'd0;
        else if (kind < 60) dt = 16'($urandom_range(1, 2500));
        else if (kind < 90) dt = 16'($urandom());
        else dt = 16'hffff;
        send_item(fx, fy, dt);
    endtask

    initial begin
        logic [23:0] speeds [6];
        sb = new();
        idle_en = 1'b1;
        long_hold = 1'b0;
        sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_force_x = '0;
        i_force_y = '0;
        i_delta_time = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed corners at the reset max_speed
        send_item(32'sh7fffffff, 32'sh7fffffff, 16'd0);
        send_item(32'sd0, 32'sd0, 16'd1);
        send_item(32'sd0, 32'sd0, 16'hffff);
        send_item(32'sh00008000, 32'sd0, 16'h0400);
        send_item(32'sh00008000, 32'sd0, 16'h0400);
        send_item(-32'sh00010000, 32'sd0, 16'h0400);
        send_item(-32'sh00010000, 32'sd0, 16'h0400);
        send_item(32'sd0, 32'sh00010000, 16'h0200);
        send_item(-32'sh00004000, 32'sh00000100, 16'h0200);
        send_item(32'sh7fffffff, 32'sh7fffffff, 16'hffff);
        send_item(32'sh80000000, 32'sh80000000, 16'hffff);
        send_item(32'sh80000000, 32'sh7fffffff, 16'h0001);
        send_item(32'sh7fffffff, 32'sh80000000, 16'h8000);
        send_item(32'sd0, 32'sd0, 16'hffff);
        send_item(32'sd1, -32'sd1, 16'h0100);
        send_item(32'sd0, 32'sd0, 16'd0);

        // random phases over several max_speed settings
        speeds[0] = 24'hffffff;
        speeds[1] = 24'd0;
        speeds[2] = 24'h004000;
        speeds[3] = 24'($urandom());
        speeds[4] = MAX_SPEED_RST;
        speeds[5] = 24'h020000;
        apb_write(ADDR_UNUSED, $urandom());
        for (int p = 0; p < 6; p++) begin
            apb_write(ADDR_MAX_SPEED, {8'($urandom()), speeds[p]});
            for (int k = 0; k < 140; k++) begin
                if (p == 2 && k == 20) long_hold = 1'b1;
                if (p == 2 && k >= 20 && k < 40)
                    send_item($urandom(), $urandom(), 16'd0);
                else
                    send_random();
                if (p == 5 && k == 40) idle_en = 1'b0;
            end
        end
        i_valid = 1'b0;

        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (2000) @(negedge i_clk);
        if (sb.pending_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("Run covered %0d items (%0d zero-step, %0d cone bends), %0d results checked,",
                 sent, sb.skips, sb.bends, sb.checked);
        $display("six max_speed settings incl. 0 and full scale, idle bursts and a long hold.");
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
